// ===== sv/fixed_size_chunk_allocator_unit_defines.svh =====
// ----------------------------------------------------------------------------
// fixed size chunk allocator assertion macros
// concurrent checks on clk, disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef FIXED_SIZE_CHUNK_ALLOCATOR_UNIT_DEFINES_SVH
`define FIXED_SIZE_CHUNK_ALLOCATOR_UNIT_DEFINES_SVH

`ifndef SYNTH

`define FSCA_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fsca: same-cycle check failed");

`define FSCA_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fsca: next-cycle check failed");

`else

`define FSCA_ASSERT_IMPL(name, ante, cons)

`define FSCA_ASSERT_NEXT(name, ante, cons)

`endif

`endif

// ===== sv/fsca_pkg.sv =====
// ----------------------------------------------------------------------------
// fsca_pkg
// register map, field widths and request codes of the chunk allocator
// ----------------------------------------------------------------------------
package fsca_pkg;

  typedef logic func_t;

  localparam func_t FUNC_ALLOC = 1'b0;
  localparam func_t FUNC_FREE  = 1'b1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_CHUNK_SIZE  = 2'd0;
  localparam cfg_idx_t REG_CHUNK_COUNT = 2'd1;
  localparam cfg_idx_t REG_POOL_BASE   = 2'd2;

  localparam int SIZE_W  = 16;
  localparam int COUNT_W = 7;
  localparam int BASE_W  = 32;

  localparam logic [SIZE_W-1:0]  SIZE_RST  = 16'd1;
  localparam logic [COUNT_W-1:0] COUNT_RST = 7'd64;
  localparam logic [BASE_W-1:0]  BASE_RST  = 32'd0;

  // widest row of the used map
  localparam int ROW_MAX = 32;

endpackage

// ===== sv/fsca_chan_if.sv =====
// ----------------------------------------------------------------------------
// fsca channels
// request and response channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface fsca_req_if #(
  parameter int ADDR_WIDTH = 32
);
  import fsca_pkg::*;

  logic                  valid;
  logic                  ready;
  func_t                 func;
  logic [ADDR_WIDTH-1:0] free_address;

  modport source (output valid, func, free_address, input ready);
  modport sink   (input valid, func, free_address, output ready);
endinterface

interface fsca_rsp_if #(
  parameter int ADDR_WIDTH = 32
);
  import fsca_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  granted;
  logic [ADDR_WIDTH-1:0] chunk_address;
  logic                  free_out_of_range;

  modport source (output valid, granted, chunk_address, free_out_of_range, input ready);
  modport sink   (input valid, granted, chunk_address, free_out_of_range, output ready);
endinterface

// ===== sv/fsca_ram.sv =====
// ----------------------------------------------------------------------------
// fsca_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module fsca_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/fsca_addsub.sv =====
// ----------------------------------------------------------------------------
// fsca_addsub
// shared adder/subtractor with carry out, no carry out means a borrow
// ----------------------------------------------------------------------------
module fsca_addsub #(
  parameter int W = 32
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] sum,
  output logic         carry
);

  logic [W:0] full;

  always_comb begin
    full  = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{W{1'b0}}, sub};
    sum   = full[W-1:0];
    carry = full[W];
  end

endmodule

// ===== sv/fixed_size_chunk_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// fixed_size_chunk_allocator_unit
// first-fit pool allocator for equal-sized chunks, one used bit per chunk
//
//   channel  dir  word fields
//   req      in   func, free_address
//   rsp      out  granted, chunk_address, free_out_of_range
//   cfg_*    in   cfg_we, cfg_index, cfg_data (write only)
//
// free: subtract the base, bit-serial divide by the chunk size on the shared
//   adder, range check, then clear the used bit; alloc: scan map rows of up to
//   32 chunks, then shift-add address multiply and add the base
// reset and any register write clear the map at once through per-row valid bits
// req.ready is high only between items; a stalled rsp holds the finished word
//   in the output register while the next item is taken in
// ----------------------------------------------------------------------------
`include "fixed_size_chunk_allocator_unit_defines.svh"

module fixed_size_chunk_allocator_unit #(
  parameter int MAX_CHUNKS = 64,
  parameter int ADDR_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [fsca_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fsca_pkg::CFG_DATA_W-1:0]    cfg_data,
  fsca_req_if.sink                           req,
  fsca_rsp_if.source                         rsp
);
  import fsca_pkg::*;

  localparam int IDX_W  = MAX_CHUNKS > 1 ? $clog2(MAX_CHUNKS) : 1;
  localparam int CNT_W  = $clog2(MAX_CHUNKS + 1);
  localparam int ROW_W  = MAX_CHUNKS < ROW_MAX ? MAX_CHUNKS : ROW_MAX;
  localparam int ROWS   = (MAX_CHUNKS + ROW_W - 1) / ROW_W;
  localparam int ROW_AW = ROWS > 1 ? $clog2(ROWS) : 1;
  localparam int BIT_W  = ROW_W > 1 ? $clog2(ROW_W) : 1;
  localparam int STEP_W = $clog2(ADDR_WIDTH);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_ALC_RD  = 4'd1;
  localparam logic [3:0] S_ALC_CHK = 4'd2;
  localparam logic [3:0] S_MUL     = 4'd3;
  localparam logic [3:0] S_ADDB    = 4'd4;
  localparam logic [3:0] S_SUB     = 4'd5;
  localparam logic [3:0] S_DIV     = 4'd6;
  localparam logic [3:0] S_FCHK    = 4'd7;
  localparam logic [3:0] S_FR_RD   = 4'd8;
  localparam logic [3:0] S_FR_WR   = 4'd9;
  localparam logic [3:0] S_DONE    = 4'd10;

  // configuration
  logic [SIZE_W-1:0]  chunk_size;
  logic [COUNT_W-1:0] chunk_count;
  logic [BASE_W-1:0]  pool_base;
  logic               cfg_hit;

  logic [SIZE_W-1:0]     size_eff;
  logic [CNT_W-1:0]      count_eff;
  logic [ADDR_WIDTH-1:0] size_ext;
  logic [ADDR_WIDTH-1:0] base;

  // sequencer
  logic [3:0]            state;
  logic [ROW_AW-1:0]     row;
  logic [CNT_W-1:0]      row_first;
  logic [ROWS-1:0]       row_valid;
  logic [ADDR_WIDTH-1:0] dq;
  logic [SIZE_W-1:0]     rem;
  logic [ADDR_WIDTH-1:0] acc;
  logic [STEP_W-1:0]     cnt;
  logic [BIT_W-1:0]      bitpos;
  logic                  res_granted;
  logic                  res_oor;

  // output register
  logic                  out_valid;
  logic                  out_granted;
  logic [ADDR_WIDTH-1:0] out_addr;
  logic                  out_oor;
  logic                  out_load;

  // used map
  logic              ram_we;
  logic [ROW_W-1:0]  ram_wdata;
  logic [ROW_W-1:0]  ram_rdata;
  logic [ROW_W-1:0]  word;
  logic [ROW_W-1:0]  avail;
  logic              found;
  logic [BIT_W-1:0]  hit;
  logic              more_rows;

  // shared unit
  logic [ADDR_WIDTH-1:0] op_a;
  logic [ADDR_WIDTH-1:0] op_b;
  logic                  op_sub;
  logic [ADDR_WIDTH-1:0] op_sum;
  logic                  op_carry;
  logic [SIZE_W:0]       rs;

  assign cfg_hit = cfg_we && (cfg_index == REG_CHUNK_SIZE || cfg_index == REG_CHUNK_COUNT ||
                              cfg_index == REG_POOL_BASE);

  always_comb begin
    size_eff  = (chunk_size == '0) ? SIZE_W'(1) : chunk_size;
    size_ext  = ADDR_WIDTH'(size_eff);
    base      = ADDR_WIDTH'(pool_base);
    count_eff = (32'(chunk_count) > 32'(MAX_CHUNKS)) ? CNT_W'(MAX_CHUNKS) : CNT_W'(chunk_count);
  end

  fsca_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROWS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (row),
    .wdata (ram_wdata),
    .raddr (row),
    .rdata (ram_rdata)
  );

  // row search
  always_comb begin
    word  = row_valid[row] ? ram_rdata : '0;
    found = 1'b0;
    hit   = '0;
    for (int j = 0; j < ROW_W; j++) begin
      avail[j] = !word[j] &&
                 ((CNT_W+1)'(row_first) + (CNT_W+1)'(j) < (CNT_W+1)'(count_eff));
    end
    for (int j = ROW_W - 1; j >= 0; j--) begin
      if (avail[j]) begin
        found = 1'b1;
        hit   = BIT_W'(j);
      end
    end
    more_rows = ((CNT_W+1)'(row_first) + (CNT_W+1)'(ROW_W)) < (CNT_W+1)'(count_eff);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = word;
    if (state == S_ALC_CHK && found) begin
      ram_we    = 1'b1;
      ram_wdata = word | (ROW_W'(1) << hit);
    end else if (state == S_FR_WR) begin
      ram_we    = 1'b1;
      ram_wdata = word & ~(ROW_W'(1) << bitpos);
    end
  end

  // operand select for the shared unit
  assign rs = {rem, dq[ADDR_WIDTH-1]};

  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_sub = 1'b0;
    case (state)
      S_MUL: begin
        op_a = acc << 1;
        op_b = dq[ADDR_WIDTH-1] ? size_ext : '0;
      end
      S_ADDB: begin
        op_a = acc;
        op_b = base;
      end
      S_SUB: begin
        op_a   = dq;
        op_b   = base;
        op_sub = 1'b1;
      end
      S_DIV: begin
        op_a   = ADDR_WIDTH'(rs);
        op_b   = size_ext;
        op_sub = 1'b1;
      end
      default: begin
        op_a = '0;
      end
    endcase
  end

  fsca_addsub #(
    .W (ADDR_WIDTH)
  ) u_alu (
    .a     (op_a),
    .b     (op_b),
    .sub   (op_sub),
    .sum   (op_sum),
    .carry (op_carry)
  );

  assign req.ready = (state == S_IDLE);
  assign out_load  = (state == S_DONE) && (!out_valid || rsp.ready);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_size  <= SIZE_RST;
      chunk_count <= COUNT_RST;
      pool_base   <= BASE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CHUNK_SIZE:  chunk_size  <= cfg_data[SIZE_W-1:0];
        REG_CHUNK_COUNT: chunk_count <= cfg_data[COUNT_W-1:0];
        REG_POOL_BASE:   pool_base   <= cfg_data[BASE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // row valid bits, a register write empties the map
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (cfg_hit) begin
      row_valid <= '0;
    end else if (ram_we) begin
      row_valid[row] <= 1'b1;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            acc         <= '0;
            res_granted <= 1'b0;
            res_oor     <= 1'b0;
            dq          <= req.free_address;
            row         <= '0;
            row_first   <= '0;
            if (req.func == FUNC_ALLOC) begin
              state <= S_ALC_RD;
            end else if (req.free_address == '0) begin
              state <= S_DONE;
            end else begin
              state <= S_SUB;
            end
          end
        end
        S_ALC_RD: begin
          state <= S_ALC_CHK;
        end
        S_ALC_CHK: begin
          if (found) begin
            dq    <= {IDX_W'(row_first + CNT_W'(hit)), {(ADDR_WIDTH-IDX_W){1'b0}}};
            cnt   <= STEP_W'(IDX_W - 1);
            state <= S_MUL;
          end else if (more_rows) begin
            row       <= row + ROW_AW'(1);
            row_first <= row_first + CNT_W'(ROW_W);
            state     <= S_ALC_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_MUL: begin
          acc <= op_sum;
          dq  <= dq << 1;
          cnt <= cnt - STEP_W'(1);
          if (cnt == '0) begin
            state <= S_ADDB;
          end
        end
        S_ADDB: begin
          acc         <= op_sum;
          res_granted <= 1'b1;
          state       <= S_DONE;
        end
        S_SUB: begin
          if (!op_carry) begin
            res_oor <= 1'b1;
            state   <= S_DONE;
          end else begin
            dq    <= op_sum;
            rem   <= '0;
            cnt   <= STEP_W'(ADDR_WIDTH - 1);
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem <= op_carry ? op_sum[SIZE_W-1:0] : rs[SIZE_W-1:0];
          dq  <= {dq[ADDR_WIDTH-2:0], op_carry};
          cnt <= cnt - STEP_W'(1);
          if (cnt == '0) begin
            state <= S_FCHK;
          end
        end
        S_FCHK: begin
          if (dq >= ADDR_WIDTH'(count_eff)) begin
            res_oor <= 1'b1;
            state   <= S_DONE;
          end else begin
            row    <= ROW_AW'(dq[IDX_W-1:0] >> BIT_W);
            bitpos <= dq[BIT_W-1:0];
            state  <= S_FR_RD;
          end
        end
        S_FR_RD: begin
          state <= S_FR_WR;
        end
        S_FR_WR: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_granted <= res_granted;
      out_addr    <= acc;
      out_oor     <= res_oor;
    end
  end

  assign rsp.valid             = out_valid;
  assign rsp.granted           = out_granted;
  assign rsp.chunk_address     = out_addr;
  assign rsp.free_out_of_range = out_oor;

  `FSCA_ASSERT_NEXT(a_cfg_clears_map, cfg_hit, row_valid == '0)
  `FSCA_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready)
  `FSCA_ASSERT_IMPL(a_rem_below_size, state == S_DIV, rem < size_eff)
  `FSCA_ASSERT_IMPL(a_oor_no_grant, out_load && res_oor, !res_granted && acc == '0)

endmodule
